// ===== design/ntl_pkg.sv =====
// Package for the nearest triangle locator: shared constants, status codes
// and item kinds. No dependencies.
package ntl_pkg;

  localparam int MAX_TRIS_DEF   = 256;
  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_BITS     = 16;
  localparam int IDX_OUT_BITS   = 8;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED    = 2'd0,
    ST_FULL     = 2'd1,
    ST_ANSWERED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Read request from the sequencer to the triangle store.
  typedef struct packed {
    logic en;
    logic last;
  } rd_ctl_t;

endpackage

// ===== design/ntl_store.sv =====
// Triangle store: one row of vertices and one row of vertex sums per triangle.
// Synchronous memories, one write and one registered read per cycle. Uses ntl_pkg.
module ntl_store
  import ntl_pkg::*;
#(
  parameter int MAX_TRIS   = MAX_TRIS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IW        = (MAX_TRIS > 1) ? $clog2(MAX_TRIS) : 1,
  localparam int TW        = 9 * COORD_BITS,
  localparam int SW        = 3 * (COORD_BITS + 2)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [TW-1:0] wr_tri,
  input  logic [SW-1:0] wr_sum,
  input  rd_ctl_t       rd_ctl,
  input  logic [IW-1:0] rd_addr,
  output logic          rd_vld,
  output logic          rd_last,
  output logic [IW-1:0] rd_idx,
  output logic [TW-1:0] rd_tri,
  output logic [SW-1:0] rd_sum
);

  logic [TW-1:0] tri_mem [MAX_TRIS];
  logic [SW-1:0] sum_mem [MAX_TRIS];
  logic          rd_vld_r;
  logic          rd_last_r;
  logic [IW-1:0] rd_idx_r;
  logic [TW-1:0] rd_tri_r;
  logic [SW-1:0] rd_sum_r;

  // Adds and scans never overlap, so no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tri_mem[wr_addr] <= wr_tri;
      sum_mem[wr_addr] <= wr_sum;
    end
    if (rd_ctl.en) begin
      rd_tri_r <= tri_mem[rd_addr];
      rd_sum_r <= sum_mem[rd_addr];
      rd_idx_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      rd_vld_r  <= rd_ctl.en;
      rd_last_r <= rd_ctl.en & rd_ctl.last;
    end
  end

  assign rd_vld  = rd_vld_r;
  assign rd_last = rd_last_r;
  assign rd_idx  = rd_idx_r;
  assign rd_tri  = rd_tri_r;
  assign rd_sum  = rd_sum_r;

endmodule

// ===== design/ntl_test.sv =====
// Pipelined containment test and centroid distance, one triangle per cycle.
// Seven register stages; wide products are built from four partial products. Uses ntl_pkg.
module ntl_test
  import ntl_pkg::*;
#(
  parameter int MAX_TRIS   = MAX_TRIS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CB        = COORD_BITS,
  localparam int IW        = (MAX_TRIS > 1) ? $clog2(MAX_TRIS) : 1,
  localparam int DSW       = 2 * CB + 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic              in_last,
  input  logic [IW-1:0]     in_idx,
  input  logic [9*CB-1:0]   in_tri,
  input  logic [3*CB+5:0]   in_sum,
  input  logic [3*CB-1:0]   pt,
  output logic              res_vld,
  output logic              res_last,
  output logic [IW-1:0]     res_idx,
  output logic              res_inside,
  output logic [DSW-1:0]    res_dist
);

  localparam int EW  = CB + 1;
  localparam int QDW = CB + 3;
  localparam int PEW = 2 * EW;
  localparam int PQW = 2 * QDW;
  localparam int DW  = 2 * CB + 4;
  localparam int H   = DW / 2;
  localparam int PW  = 2 * DW;
  localparam int QW  = PW + 2;
  localparam int NS  = 7;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] last_r;
  logic [IW-1:0] idx_r [NS];

  // Stage 1: edges and offset from three times the centroid.
  logic signed [EW-1:0]  e0_nxt [3], e1_nxt [3], w_nxt [3];
  logic signed [QDW-1:0] dd_nxt [3];
  logic signed [EW-1:0]  e0_r [3], e1_r [3], w_r [3];
  logic signed [QDW-1:0] dd_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [CB-1:0] va, vb, vc, vp;
      logic signed [CB+1:0] vs;
      va = in_tri[CB*k +: CB];
      vb = in_tri[CB*(k+3) +: CB];
      vc = in_tri[CB*(k+6) +: CB];
      vp = pt[CB*k +: CB];
      vs = in_sum[(CB+2)*k +: CB+2];
      e0_nxt[k] = EW'(vc) - EW'(va);
      e1_nxt[k] = EW'(vb) - EW'(va);
      w_nxt[k]  = EW'(vp) - EW'(va);
      dd_nxt[k] = (QDW'(vp) <<< 1) + QDW'(vp) - QDW'(vs);
    end
  end

  // Stage 2: component products.
  logic signed [PEW-1:0] p00_r [3], p01_r [3], p02_r [3], p11_r [3], p12_r [3];
  logic signed [PQW-1:0] pq_r [3];

  // Stage 3: dot products and squared distance.
  logic signed [DW-1:0] d00_r, d01_r, d02_r, d11_r, d12_r;
  logic [DSW-1:0]       dist_r [NS];

  // Stage 4: partial products of the six wide products.
  logic signed [DW-1:0]  opa [6], opb [6];
  logic signed [2*H-1:0] hh_r [6];
  logic signed [2*H:0]   hl_r [6], lh_r [6];
  logic [2*H-1:0]        ll_r [6];

  always_comb begin
    opa[0] = d00_r; opb[0] = d11_r;
    opa[1] = d01_r; opb[1] = d01_r;
    opa[2] = d11_r; opb[2] = d02_r;
    opa[3] = d01_r; opb[3] = d12_r;
    opa[4] = d00_r; opb[4] = d12_r;
    opa[5] = d01_r; opb[5] = d02_r;
  end

  // Stage 5: wide products; stage 6: determinant and numerators.
  logic signed [PW-1:0] prod_r [6];
  logic signed [QW-1:0] den_r, nu_r, nv_r;
  logic signed [QW-1:0] uv_sum;
  logic                 inside_r;

  assign uv_sum = nu_r + nv_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e0_r[k]  <= e0_nxt[k];
      e1_r[k]  <= e1_nxt[k];
      w_r[k]   <= w_nxt[k];
      dd_r[k]  <= dd_nxt[k];
      p00_r[k] <= e0_r[k] * e0_r[k];
      p01_r[k] <= e0_r[k] * e1_r[k];
      p02_r[k] <= e0_r[k] * w_r[k];
      p11_r[k] <= e1_r[k] * e1_r[k];
      p12_r[k] <= e1_r[k] * w_r[k];
      pq_r[k]  <= dd_r[k] * dd_r[k];
    end
    d00_r <= DW'(p00_r[0]) + DW'(p00_r[1]) + DW'(p00_r[2]);
    d01_r <= DW'(p01_r[0]) + DW'(p01_r[1]) + DW'(p01_r[2]);
    d02_r <= DW'(p02_r[0]) + DW'(p02_r[1]) + DW'(p02_r[2]);
    d11_r <= DW'(p11_r[0]) + DW'(p11_r[1]) + DW'(p11_r[2]);
    d12_r <= DW'(p12_r[0]) + DW'(p12_r[1]) + DW'(p12_r[2]);
    dist_r[2] <= DSW'($unsigned(pq_r[0])) + DSW'($unsigned(pq_r[1]))
               + DSW'($unsigned(pq_r[2]));
    for (int s = 3; s < NS; s++) begin
      dist_r[s] <= dist_r[s-1];
    end
    for (int j = 0; j < 6; j++) begin
      hh_r[j] <= $signed(opa[j][DW-1:H]) * $signed(opb[j][DW-1:H]);
      hl_r[j] <= $signed(opa[j][DW-1:H]) * $signed({1'b0, opb[j][H-1:0]});
      lh_r[j] <= $signed({1'b0, opa[j][H-1:0]}) * $signed(opb[j][DW-1:H]);
      ll_r[j] <= opa[j][H-1:0] * opb[j][H-1:0];
      prod_r[j] <= (PW'(hh_r[j]) <<< (2 * H))
                 + ((PW'(hl_r[j]) + PW'(lh_r[j])) <<< H)
                 + $signed(PW'(ll_r[j]));
    end
    den_r <= QW'(prod_r[0]) - QW'(prod_r[1]);
    nu_r  <= QW'(prod_r[2]) - QW'(prod_r[3]);
    nv_r  <= QW'(prod_r[4]) - QW'(prod_r[5]);
    // A degenerate triangle has a zero determinant and fails the first term.
    inside_r <= (den_r > 0) && !nu_r[QW-1] && !nv_r[QW-1] && (uv_sum < den_r);
    idx_r[0] <= in_idx;
    for (int s = 1; s < NS; s++) begin
      idx_r[s] <= idx_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      last_r <= '0;
    end else begin
      vld_r  <= {vld_r[NS-2:0], in_vld};
      last_r <= {last_r[NS-2:0], in_vld & in_last};
    end
  end

  assign res_vld    = vld_r[NS-1];
  assign res_last   = last_r[NS-1];
  assign res_idx    = idx_r[NS-1];
  assign res_inside = inside_r;
  assign res_dist   = dist_r[NS-1];

endmodule

// ===== design/nearest_triangle_locator_unit.sv =====
// Nearest triangle locator, top level: sequencer, triangle store and test pipeline.
// An add sets the result registers on acceptance. In S_DONE a result moves to the output
// register once that register is free, and the FSM returns to S_IDLE for the next item. A
// query on N stored triangles goes to S_DONE once its last result leaves the seven-stage
// test pipeline, fed one store row per cycle. One item is worked on at a time;
// a result can only wait in the output register while the next item is accepted.
// Reset (rst_n, synchronous, active low) clears the count and control; memories keep data.
module nearest_triangle_locator_unit
  import ntl_pkg::*;
#(
  parameter int MAX_TRIS   = MAX_TRIS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,  // ax, ay, az, bx, by_coord, bz, cx, cy, cz
  input  logic [0:0]   in_tuser,  // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata, // tri_index, inside_res, zero fill
  output logic [1:0]   out_tuser  // status
);

  localparam int CB  = COORD_BITS;
  localparam int IW  = (MAX_TRIS > 1) ? $clog2(MAX_TRIS) : 1;
  localparam int CW  = $clog2(MAX_TRIS + 1);
  localparam int TW  = 9 * CB;
  localparam int SW  = 3 * (CB + 2);
  localparam int DSW = 2 * CB + 8;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t         state_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  issue_r;
  logic [3*CB-1:0] pt_r;
  logic           found_r, first_r;
  logic [IW-1:0]  best_r;
  logic [DSW-1:0] best_dist_r;
  status_t        res_status_r;
  logic [IW-1:0]  res_idx_r;
  logic           res_inside_r;
  logic           out_valid_r;
  status_t        out_status_r;
  logic [IW-1:0]  out_idx_r;
  logic           out_inside_r;

  logic           accept;
  logic [TW-1:0]  new_tri;
  logic [SW-1:0]  new_sum;
  rd_ctl_t        rd_ctl;
  logic           rd_vld, rd_last;
  logic [IW-1:0]  rd_idx;
  logic [TW-1:0]  rd_tri;
  logic [SW-1:0]  rd_sum;
  logic           t_vld, t_last, t_inside;
  logic [IW-1:0]  t_idx;
  logic [DSW-1:0] t_dist;
  logic           found_nxt, first_nxt;
  logic [IW-1:0]  best_nxt;
  logic [DSW-1:0] best_dist_nxt;
  logic           wr_en;

  assign accept = in_tvalid & in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign wr_en = accept && (in_tuser[0] == KIND_ADD) && (count_r < CW'(MAX_TRIS));

  // Coordinates come from the low COORD_BITS bits of each 16-bit field.
  always_comb begin
    for (int v = 0; v < 9; v++) begin
      new_tri[CB*v +: CB] = CB'(in_tdata[FIELD_BITS*v +: FIELD_BITS]);
    end
    for (int k = 0; k < 3; k++) begin
      new_sum[(CB+2)*k +: CB+2] = (CB+2)'($signed(new_tri[CB*k +: CB]))
                                + (CB+2)'($signed(new_tri[CB*(k+3) +: CB]))
                                + (CB+2)'($signed(new_tri[CB*(k+6) +: CB]));
    end
  end

  assign rd_ctl.en   = (state_r == S_SCAN) && (issue_r < count_r);
  assign rd_ctl.last = (issue_r + CW'(1)) == count_r;

  ntl_store #(.MAX_TRIS(MAX_TRIS), .COORD_BITS(COORD_BITS)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (count_r[IW-1:0]),
    .wr_tri  (new_tri),
    .wr_sum  (new_sum),
    .rd_ctl  (rd_ctl),
    .rd_addr (issue_r[IW-1:0]),
    .rd_vld  (rd_vld),
    .rd_last (rd_last),
    .rd_idx  (rd_idx),
    .rd_tri  (rd_tri),
    .rd_sum  (rd_sum)
  );

  ntl_test #(.MAX_TRIS(MAX_TRIS), .COORD_BITS(COORD_BITS)) u_test (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (rd_vld),
    .in_last    (rd_last),
    .in_idx     (rd_idx),
    .in_tri     (rd_tri),
    .in_sum     (rd_sum),
    .pt         (pt_r),
    .res_vld    (t_vld),
    .res_last   (t_last),
    .res_idx    (t_idx),
    .res_inside (t_inside),
    .res_dist   (t_dist)
  );

  // Results return in store order; the first containing triangle is kept, later ones ignored.
  always_comb begin
    found_nxt     = found_r;
    first_nxt     = first_r;
    best_nxt      = best_r;
    best_dist_nxt = best_dist_r;
    if (t_vld && !found_r) begin
      first_nxt = 1'b0;
      if (t_inside) begin
        found_nxt = 1'b1;
        best_nxt  = t_idx;
      end else if (first_r || (t_dist < best_dist_r)) begin
        best_nxt      = t_idx;
        best_dist_nxt = t_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      found_r     <= 1'b0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded below instead.
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_tuser[0] == KIND_ADD) begin
              res_inside_r <= 1'b0;
              state_r      <= S_DONE;
              if (wr_en) begin
                res_status_r <= ST_ADDED;
                res_idx_r    <= count_r[IW-1:0];
                count_r      <= count_r + CW'(1);
              end else begin
                res_status_r <= ST_FULL;
                res_idx_r    <= '0;
              end
            end else if (count_r == '0) begin
              res_status_r <= ST_EMPTY;
              res_idx_r    <= '0;
              res_inside_r <= 1'b0;
              state_r      <= S_DONE;
            end else begin
              pt_r    <= new_tri[3*CB-1:0];
              issue_r <= '0;
              found_r <= 1'b0;
              first_r <= 1'b1;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_ctl.en) begin
            issue_r <= issue_r + CW'(1);
          end
          found_r     <= found_nxt;
          first_r     <= first_nxt;
          best_r      <= best_nxt;
          best_dist_r <= best_dist_nxt;
          if (t_vld && t_last) begin
            res_status_r <= ST_ANSWERED;
            res_idx_r    <= best_nxt;
            res_inside_r <= found_nxt;
            state_r      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_idx_r    <= res_idx_r;
            out_inside_r <= res_inside_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'b0, out_inside_r, IDX_OUT_BITS'(out_idx_r)};

endmodule
